[src/qoi_pkg.sv]
// qoi_pkg: shared types, constants and helper functions of the qoi image decoder
// used by every module under src; no dependencies

package qoi_pkg;

    // sizes
    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = 13;
    localparam int LEFT_W   = 25;
    localparam int RUN_W    = 6;
    localparam int IDX_W    = 6;
    localparam int IDX_N    = 64;
    localparam int APB_AW   = 3;

    // register indexes on the configuration port
    localparam logic REG_MAX_WIDTH  = 1'b0;
    localparam logic REG_MAX_HEIGHT = 1'b1;

    // op bytes and two-bit tags
    localparam logic [7:0] OP_RGB     = 8'hFE;
    localparam logic [7:0] OP_RGBA    = 8'hFF;
    localparam logic [1:0] TAG_INDEX  = 2'b00;
    localparam logic [1:0] TAG_DIFF   = 2'b01;
    localparam logic [1:0] TAG_LUMA   = 2'b10;
    localparam logic [1:0] TAG_RUN    = 2'b11;

    // header byte positions
    localparam logic [3:0] HDR_WIDTH_POS    = 4'd4;
    localparam logic [3:0] HDR_HEIGHT_POS   = 4'd8;
    localparam logic [3:0] HDR_HEIGHT_LAST  = 4'd11;
    localparam logic [3:0] HDR_CHANNELS_POS = 4'd12;
    localparam logic [7:0] CHANNELS_RGB     = 8'd3;
    localparam logic [7:0] CHANNELS_RGBA    = 8'd4;

    localparam logic [7:0] MAGIC [4] = '{8'h71, 8'h6F, 8'h69, 8'h66};

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_SIZE     = 3'd2;
    localparam logic [2:0] ERR_CHANNELS = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    // decoder phase kept by the datapath
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_OP,
        PH_OPERAND,
        PH_IDLE
    } phase_t;

    // controller states
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_DECODE,
        ST_HASH,
        ST_PIXEL,
        ST_DONE,
        ST_ERROR,
        ST_TRUNC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic hash_write;
        logic load_pixel;
        logic load_done;
        logic load_error;
        logic load_trunc;
        logic end_byte;
    } qoi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hdr_err;
        logic emit;
        logic phase_idle;
        logic eos;
        logic run_zero;
        logic left_zero;
        logic out_free;
    } qoi_status_t;

    // color index slot of a pixel packed as {alpha, blue, green, red}
    function automatic logic [IDX_W-1:0] qoi_hash(input logic [31:0] px);
        logic [IDX_W-1:0] h;
        h = px[5:0] * 6'd3 + px[13:8] * 6'd5 + px[21:16] * 6'd7 + px[29:24] * 6'd11;
        return h;
    endfunction

endpackage

[src/qoi_regs.sv]
// qoi_regs: apb configuration registers (max_width, max_height)
// depends on qoi_pkg

module qoi_regs
    import qoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [SIDE_W-1:0] max_width,
    output logic [SIDE_W-1:0] max_height
);

    logic [SIDE_W-1:0] max_width_reg;
    logic [SIDE_W-1:0] max_height_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_width_reg  <= SIDE_W'(32);
            max_height_reg <= SIDE_W'(32);
        end else if (wr_en) begin
            if (paddr[2] == REG_MAX_WIDTH) begin
                max_width_reg <= pwdata[SIDE_W-1:0];
            end else begin
                max_height_reg <= pwdata[SIDE_W-1:0];
            end
        end
    end

    // read mux
    always_comb begin
        if (paddr[2] == REG_MAX_WIDTH) begin
            prdata = {{(32-SIDE_W){1'b0}}, max_width_reg};
        end else begin
            prdata = {{(32-SIDE_W){1'b0}}, max_height_reg};
        end
    end

    assign max_width  = max_width_reg;
    assign max_height = max_height_reg;

endmodule

[src/qoi_ctrl.sv]
// qoi_ctrl: per-byte sequencer of the qoi decoder
// depends on qoi_pkg; drives qoi_datapath through qoi_cmd_t

module qoi_ctrl
    import qoi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  qoi_status_t status,
    output qoi_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FETCH;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.hdr_err) begin
                    state_next = ST_ERROR;
                end else if (status.emit) begin
                    state_next = ST_HASH;
                end else if (status.eos && !status.phase_idle) begin
                    state_next = ST_TRUNC;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_HASH: begin
                state_next = ST_PIXEL;
            end
            ST_PIXEL: begin
                if (status.run_zero || status.left_zero) begin
                    if (status.left_zero) begin
                        state_next = ST_DONE;
                    end else if (status.eos) begin
                        state_next = ST_TRUNC;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DONE, ST_ERROR, ST_TRUNC: begin
                if (status.out_free) begin
                    state_next = ST_FETCH;
                end
            end
            default: begin
                state_next = ST_FETCH;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_FETCH: begin
                // no transfer is taken while reset is held
                s_tready   = aresetn;
                cmd.accept = s_tvalid & aresetn;
            end
            ST_DECODE: begin
                cmd.decode   = 1'b1;
                cmd.end_byte = !status.hdr_err && !status.emit &&
                               !(status.eos && !status.phase_idle);
            end
            ST_HASH: begin
                cmd.hash_write = 1'b1;
            end
            ST_PIXEL: begin
                if (status.run_zero || status.left_zero) begin
                    cmd.end_byte = !status.left_zero && !status.eos;
                end else begin
                    cmd.load_pixel = status.out_free;
                end
            end
            ST_DONE: begin
                cmd.load_done = status.out_free;
                cmd.end_byte  = status.out_free;
            end
            ST_ERROR: begin
                cmd.load_error = status.out_free;
                cmd.end_byte   = status.out_free;
            end
            ST_TRUNC: begin
                cmd.load_trunc = status.out_free;
                cmd.end_byte   = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/qoi_datapath.sv]
// qoi_datapath: header parser, op decoder, color index memory and output register
// depends on qoi_pkg; sequenced by qoi_ctrl

module qoi_datapath
    import qoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  qoi_cmd_t          cmd,
    output qoi_status_t       status,
    input  logic [7:0]        in_byte,
    input  logic              in_eos,
    input  logic [SIDE_W-1:0] max_width,
    input  logic [SIDE_W-1:0] max_height,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    // input byte and color index read port
    logic [7:0]        byte_reg;
    logic              eos_reg;
    logic [31:0]       idx_mem [IDX_N];
    logic [IDX_N-1:0]  idx_valid_reg;
    logic [31:0]       rd_data_reg;
    logic              rd_valid_reg;

    // decoder state
    phase_t            phase_reg,  phase_next;
    logic [3:0]        pos_reg,    pos_next;
    logic [31:0]       ws_reg,     ws_next;
    logic [31:0]       hs_reg,     hs_next;
    logic [LEFT_W-1:0] left_reg,   left_next;
    logic [7:0]        pend_reg,   pend_next;
    logic [2:0]        opcnt_reg,  opcnt_next;
    logic [RUN_W-1:0]  run_reg,    run_next;
    logic [2:0]        code_reg,   code_next;
    logic [7:0]        red_reg,    red_next;
    logic [7:0]        green_reg,  green_next;
    logic [7:0]        blue_reg,   blue_next;
    logic [7:0]        alpha_reg,  alpha_next;

    // output register
    logic              ovalid_reg;
    logic [63:0]       odata_reg;
    logic [1:0]        okind_reg;
    logic              olast_reg;

    // decode helpers
    logic              dec_err;
    logic [2:0]        dec_code;
    logic              dec_emit;
    logic              idx_clear;
    logic [31:0]       hs_shift;
    logic [SIDE_W-1:0] lim_w;
    logic [SIDE_W-1:0] lim_h;
    logic [2*SIDE_W-1:0] area;
    logic [2:0]        opcnt_inc;
    logic [2:0]        need;
    logic [7:0]        vg;
    logic [31:0]       cur_px;
    logic [IDX_W-1:0]  wr_slot;
    logic              out_free;

    assign cur_px   = {alpha_reg, blue_reg, green_reg, red_reg};
    assign wr_slot  = qoi_hash(cur_px);
    assign out_free = !ovalid_reg || m_tready;
    assign hs_shift = {hs_reg[23:0], byte_reg};
    assign lim_w    = (max_width  > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : max_width;
    assign lim_h    = (max_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : max_height;
    assign area     = ws_reg[SIDE_W-1:0] * hs_reg[SIDE_W-1:0];
    assign opcnt_inc = opcnt_reg + 3'd1;
    assign need     = (pend_reg == OP_RGBA) ? 3'd4 : 3'd3;
    assign vg       = {2'b00, pend_reg[5:0]} - 8'd32;

    // byte latch and registered color index read
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg     <= in_byte;
            eos_reg      <= in_eos;
            rd_data_reg  <= idx_mem[in_byte[IDX_W-1:0]];
            rd_valid_reg <= idx_valid_reg[in_byte[IDX_W-1:0]];
        end
        if (cmd.hash_write) begin
            idx_mem[wr_slot] <= cur_px;
        end
    end

    // index valid bits, cleared by reset and by each new header
    always_ff @(posedge aclk) begin
        if (!aresetn || idx_clear) begin
            idx_valid_reg <= '0;
        end else if (cmd.hash_write) begin
            idx_valid_reg[wr_slot] <= 1'b1;
        end
    end

    // next-state logic of the decoder
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ws_next    = ws_reg;
        hs_next    = hs_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        opcnt_next = opcnt_reg;
        run_next   = run_reg;
        code_next  = code_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        alpha_next = alpha_reg;
        dec_err    = 1'b0;
        dec_code   = ERR_NONE;
        dec_emit   = 1'b0;
        idx_clear  = 1'b0;

        // byte decode
        case (phase_reg)
            PH_HEADER: begin
                if (pos_reg < HDR_WIDTH_POS) begin
                    if (byte_reg != MAGIC[pos_reg[1:0]]) begin
                        dec_err  = 1'b1;
                        dec_code = ERR_MAGIC;
                    end
                end else if (pos_reg < HDR_HEIGHT_POS) begin
                    ws_next = {ws_reg[23:0], byte_reg};
                end else if (pos_reg < HDR_CHANNELS_POS) begin
                    hs_next = hs_shift;
                    if (pos_reg == HDR_HEIGHT_LAST &&
                        (ws_reg == '0 || hs_shift == '0 ||
                         ws_reg > {{(32-SIDE_W){1'b0}}, lim_w} ||
                         hs_shift > {{(32-SIDE_W){1'b0}}, lim_h})) begin
                        dec_err  = 1'b1;
                        dec_code = ERR_SIZE;
                    end
                end else if (pos_reg == HDR_CHANNELS_POS) begin
                    if (byte_reg != CHANNELS_RGB && byte_reg != CHANNELS_RGBA) begin
                        dec_err  = 1'b1;
                        dec_code = ERR_CHANNELS;
                    end
                end else begin
                    // colorspace byte: start of the pixel data
                    idx_clear  = cmd.decode;
                    red_next   = 8'd0;
                    green_next = 8'd0;
                    blue_next  = 8'd0;
                    alpha_next = 8'd255;
                    left_next  = area[LEFT_W-1:0];
                    phase_next = PH_OP;
                end
                if (dec_err) begin
                    phase_next = PH_IDLE;
                    code_next  = dec_code;
                end else begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            PH_OP: begin
                if (byte_reg == OP_RGB || byte_reg == OP_RGBA ||
                    byte_reg[7:6] == TAG_LUMA) begin
                    pend_next  = byte_reg;
                    opcnt_next = 3'd0;
                    phase_next = PH_OPERAND;
                end else if (byte_reg[7:6] == TAG_INDEX) begin
                    if (rd_valid_reg) begin
                        red_next   = rd_data_reg[7:0];
                        green_next = rd_data_reg[15:8];
                        blue_next  = rd_data_reg[23:16];
                        alpha_next = rd_data_reg[31:24];
                    end else begin
                        red_next   = 8'd0;
                        green_next = 8'd0;
                        blue_next  = 8'd0;
                        alpha_next = 8'd0;
                    end
                    run_next = RUN_W'(1);
                    dec_emit = 1'b1;
                end else if (byte_reg[7:6] == TAG_DIFF) begin
                    red_next   = red_reg   + {6'd0, byte_reg[5:4]} - 8'd2;
                    green_next = green_reg + {6'd0, byte_reg[3:2]} - 8'd2;
                    blue_next  = blue_reg  + {6'd0, byte_reg[1:0]} - 8'd2;
                    run_next   = RUN_W'(1);
                    dec_emit   = 1'b1;
                end else begin
                    // run: bias of one, the two top codes are taken by rgb and rgba
                    run_next = byte_reg[RUN_W-1:0] + RUN_W'(1);
                    dec_emit = 1'b1;
                end
            end
            PH_OPERAND: begin
                if (pend_reg == OP_RGB || pend_reg == OP_RGBA) begin
                    case (opcnt_reg[1:0])
                        2'd0:    red_next   = byte_reg;
                        2'd1:    green_next = byte_reg;
                        2'd2:    blue_next  = byte_reg;
                        default: alpha_next = byte_reg;
                    endcase
                    opcnt_next = opcnt_inc;
                    if (opcnt_inc >= need) begin
                        phase_next = PH_OP;
                        run_next   = RUN_W'(1);
                        dec_emit   = 1'b1;
                    end
                end else begin
                    // luma: green delta in the op, red and blue offsets in this byte
                    red_next   = red_reg + vg - 8'd8 + {4'd0, byte_reg[7:4]};
                    green_next = green_reg + vg;
                    blue_next  = blue_reg + vg - 8'd8 + {4'd0, byte_reg[3:0]};
                    phase_next = PH_OP;
                    run_next   = RUN_W'(1);
                    dec_emit   = 1'b1;
                end
            end
            default: begin
                dec_emit = 1'b0;
            end
        endcase

        // without a decode step only the sequencing updates below apply
        if (!cmd.decode) begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            ws_next    = ws_reg;
            hs_next    = hs_reg;
            left_next  = left_reg;
            pend_next  = pend_reg;
            opcnt_next = opcnt_reg;
            run_next   = run_reg;
            code_next  = code_reg;
            red_next   = red_reg;
            green_next = green_reg;
            blue_next  = blue_reg;
            alpha_next = alpha_reg;
        end

        // one pixel out
        if (cmd.load_pixel) begin
            run_next  = run_reg - RUN_W'(1);
            left_next = left_reg - LEFT_W'(1);
        end

        // image complete or header error leaves the decoder idle
        if (cmd.load_done || cmd.load_error) begin
            phase_next = PH_IDLE;
        end

        // end of file: back to the header for the next one
        if (cmd.end_byte && eos_reg) begin
            pos_next   = 4'd0;
            ws_next    = '0;
            hs_next    = '0;
            left_next  = '0;
            pend_next  = 8'd0;
            opcnt_next = 3'd0;
            phase_next = PH_HEADER;
        end
    end

    // decoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 4'd0;
            ws_reg    <= '0;
            hs_reg    <= '0;
            left_reg  <= '0;
            pend_reg  <= 8'd0;
            opcnt_reg <= 3'd0;
            run_reg   <= '0;
            code_reg  <= ERR_NONE;
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
            alpha_reg <= 8'd255;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ws_reg    <= ws_next;
            hs_reg    <= hs_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            opcnt_reg <= opcnt_next;
            run_reg   <= run_next;
            code_reg  <= code_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.load_pixel || cmd.load_done || cmd.load_error || cmd.load_trunc) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    // output payload: {pad, height, width, error code, alpha, blue, green, red}
    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            odata_reg <= {32'd0, cur_px};
            okind_reg <= KIND_PIXEL;
            olast_reg <= (run_reg == RUN_W'(1)) && (left_reg != LEFT_W'(1)) && !eos_reg;
        end else if (cmd.load_done) begin
            odata_reg <= {3'd0, hs_reg[SIDE_W-1:0], ws_reg[SIDE_W-1:0], ERR_NONE, 32'd0};
            okind_reg <= KIND_DONE;
            olast_reg <= 1'b1;
        end else if (cmd.load_error) begin
            odata_reg <= {29'd0, code_reg, 32'd0};
            okind_reg <= KIND_ERROR;
            olast_reg <= 1'b1;
        end else if (cmd.load_trunc) begin
            odata_reg <= {29'd0, ERR_TRUNC, 32'd0};
            okind_reg <= KIND_ERROR;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

    // status to the controller
    assign status.hdr_err    = dec_err;
    assign status.emit       = dec_emit;
    assign status.phase_idle = (phase_reg == PH_IDLE);
    assign status.eos        = eos_reg;
    assign status.run_zero   = (run_reg == '0);
    assign status.left_zero  = (left_reg == '0);
    assign status.out_free   = out_free;

endmodule

[src/qoi_image_decoder.sv]
// qoi_image_decoder: top level of the qoi byte-stream image decoder
// depends on qoi_pkg, qoi_regs, qoi_ctrl, qoi_datapath
//
//  channel   ports               payload
//  input     s_t*                tdata[7:0] data byte, tlast end of stream
//  result    m_t*                tdata pixel/dims/error, tuser kind, tlast last of run
//  config    psel..prdata (apb)  max_width at 0x0, max_height at 0x4
//
// a byte that makes no pixel passes fetch and decode; a byte that makes n pixels
// passes fetch, decode, the color index write and a closing check of the run
// around one output transfer per cycle while the output register is free.
// reset is synchronous and needs no clearing pass. the sequencer holds in a
// state that loads a result while a result waits and m_tready is low; one
// result can wait in the output register while the next byte is taken.

module qoi_image_decoder
    import qoi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tlast,   // end_of_stream
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // red, green, blue, alpha, error_code,
                                         // image_width, image_height, zero pad
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast,   // last_of_run
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SIDE_W-1:0] max_width;
    logic [SIDE_W-1:0] max_height;
    qoi_cmd_t          cmd;
    qoi_status_t       status;

    qoi_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_width  (max_width),
        .max_height (max_height)
    );

    qoi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qoi_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .max_width  (max_width),
        .max_height (max_height),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
